// ----- rtl/psm_pkg.sv -----
// Types, codes and helper functions shared by the plateau segment merger.
package psm_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_CLASS,
    S_SETA,
    S_EMIT_INC,
    S_REL_A,
    S_REL_RD,
    S_REL_HE,
    S_MA,
    S_AA,
    S_MI,
    S_AI,
    S_DSET,
    S_DRUN,
    S_HCHK,
    S_HRD,
    S_HMUL,
    S_HACC,
    S_CMP,
    S_FIN
  } state_t;

  localparam logic [1:0] CFG_MAX_GAP     = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE   = 2'd1;
  localparam logic [1:0] CFG_PLATEAU     = 2'd2;
  localparam logic [1:0] CFG_WEIGHT_MODE = 2'd3;

  localparam logic [21:0] NODE_MAX = 22'h3FFFFF;

  function automatic logic [32:0] seg_len(input logic [31:0] s, input logic [31:0] e);
    seg_len = (e >= s) ? ({1'b0, e} - {1'b0, s} + 33'd1) : 33'd0;
  endfunction

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    abs_diff = d[32] ? 33'(-d) : 33'(d);
  endfunction

endpackage

// ----- rtl/plateau_segment_merger.sv -----
// Plateau segment merger: holds short segments behind anchors and merges close anchors.
// Items are taken one at a time: in_stall is low only while the block is idle. A store, a
// single emit or a new anchor runs S_DECIDE and S_CLASS, then S_EMIT_INC or S_SETA if needed,
// and S_FIN; a flush releases the anchor in S_REL_A and each held segment in S_REL_RD and
// S_REL_HE, plus any wait on out_stall. A merge attempt runs one shared multiplier and one
// radix-2 divider under the sequencer (two 32-step divisions, each skipped when its weight
// sum is zero, and each held segment read from the hold memory through S_HCHK, S_HRD, S_HMUL
// and S_HACC), followed by a release if the merge fails. Results leave through an output
// register, so one finished beat may wait on out_stall while the sequencer continues.
module plateau_segment_merger #(
  parameter int HOLD_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_group_tag,
  input  logic [31:0] in_seg_start,
  input  logic [31:0] in_seg_end,
  input  logic signed [31:0] in_seg_value,
  input  logic [15:0] in_node_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_group,
  output logic [31:0] out_start,
  output logic [31:0] out_end,
  output logic signed [31:0] out_value,
  output logic [21:0] out_nodes,
  output logic        out_last
);

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int TW = $clog2(HOLD_DEPTH + 2);
  localparam int AW = 66 + TW;
  localparam int DW = 33 + TW;
  localparam int EW = 112;

  psm_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [23:0] max_gap_r;
  logic [30:0] tol_r;
  logic [15:0] plateau_r;
  logic        wmode_r;

  logic        it_op_r;
  logic [15:0] it_grp_r;
  logic [31:0] it_s_r, it_e_r, it_v_r;
  logic [15:0] it_n_r;

  logic        seen_r, seen_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic        av_r, av_nxt;
  logic [31:0] as_r, as_nxt, ae_r, ae_nxt, aval_r, aval_nxt;
  logic [21:0] an_r, an_nxt;
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic [16:0] hls_r, hls_nxt;

  logic signed [65:0] prod_r, prod_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] d_r, d_nxt, rem_r, rem_nxt;
  logic [23:0] nsum_r, nsum_nxt;
  logic [31:0] lo_r, lo_nxt, q_r, q_nxt, tv1_r, tv1_nxt, tv2_r, tv2_nxt;
  logic        neg_r, neg_nxt, dsel_r, dsel_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;

  logic        ov_r, ov_nxt, ol_r, ol_nxt;
  logic [15:0] og_r, og_nxt;
  logic [31:0] os_r, os_nxt, oe_r, oe_nxt, ovl_r, ovl_nxt;
  logic [21:0] on_r, on_nxt;

  logic [EW-1:0] mem [HOLD_DEPTH];
  logic [EW-1:0] rd_r, wdata;
  logic          we;

  logic [32:0] len_c, alen_c, hlen_c, wa_c, wi_c, hw_c, mul_w;
  logic [31:0] mul_v, hs_c, he_c, hv_c;
  logic [15:0] hn_c;
  logic signed [65:0] prod_c;
  logic        short_c, out_free, inc_follows, gap_bad, val_bad, ge_c;
  logic signed [33:0] gap_c;
  logic [17:0] sum_c;
  logic [AW-1:0] mag_c;
  logic [DW:0] t_c;

  assign in_stall  = (state_r != psm_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_group = og_r;
  assign out_start = os_r;
  assign out_end   = oe_r;
  assign out_value = ovl_r;
  assign out_nodes = on_r;
  assign out_last  = ol_r;

  assign out_free = !ov_r || !out_stall;
  assign {hs_c, he_c, hv_c, hn_c} = rd_r;
  assign len_c  = psm_pkg::seg_len(it_s_r, it_e_r);
  assign alen_c = psm_pkg::seg_len(as_r, ae_r);
  assign hlen_c = psm_pkg::seg_len(hs_c, he_c);
  assign wa_c = wmode_r ? alen_c : {11'd0, an_r};
  assign wi_c = wmode_r ? len_c : {17'd0, it_n_r};
  assign hw_c = wmode_r ? hlen_c : {17'd0, hn_c};
  assign short_c = len_c < {17'd0, plateau_r};
  assign inc_follows = (ret_r == psm_pkg::S_EMIT_INC) || (ret_r == psm_pkg::S_CLASS && short_c);
  assign gap_c = $signed({2'b00, it_s_r}) - $signed({2'b00, ae_r});
  assign gap_bad = gap_c > $signed({10'd0, max_gap_r});
  assign val_bad = psm_pkg::abs_diff(it_v_r, aval_r) > {2'b00, tol_r};
  assign sum_c = {1'b0, hls_r} + {2'b00, len_c[15:0]};
  assign prod_c = $signed(mul_v) * $signed({1'b0, mul_w});
  assign mag_c = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign t_c = {rem_r, lo_r[31]};
  assign ge_c = t_c >= {1'b0, d_r};

  always_comb begin
    unique case (state_r)
      psm_pkg::S_MI: begin
        mul_v = it_v_r;
        mul_w = wi_c;
      end
      psm_pkg::S_HMUL: begin
        mul_v = hv_c;
        mul_w = hw_c;
      end
      default: begin
        mul_v = aval_r;
        mul_w = wa_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[count_r[IW-1:0]] <= wdata;
    end
    rd_r <= mem[idx_r[IW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    seen_nxt = seen_r;
    prev_nxt = prev_r;
    av_nxt = av_r;
    as_nxt = as_r;
    ae_nxt = ae_r;
    aval_nxt = aval_r;
    an_nxt = an_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    hls_nxt = hls_r;
    prod_nxt = prod_r;
    acc_nxt = acc_r;
    d_nxt = d_r;
    nsum_nxt = nsum_r;
    rem_nxt = rem_r;
    lo_nxt = lo_r;
    q_nxt = q_r;
    neg_nxt = neg_r;
    dsel_nxt = dsel_r;
    dcnt_nxt = dcnt_r;
    tv1_nxt = tv1_r;
    tv2_nxt = tv2_r;
    ov_nxt = ov_r && out_stall;
    ol_nxt = ol_r;
    og_nxt = og_r;
    os_nxt = os_r;
    oe_nxt = oe_r;
    ovl_nxt = ovl_r;
    on_nxt = on_r;
    we = 1'b0;
    wdata = {it_s_r, it_e_r, it_v_r, it_n_r};

    unique case (state_r)
      psm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = psm_pkg::S_DECIDE;
        end
      end
      psm_pkg::S_DECIDE: begin
        if (it_op_r) begin
          ret_nxt = psm_pkg::S_FIN;
          state_nxt = psm_pkg::S_REL_A;
        end else if (seen_r && it_grp_r != prev_r) begin
          ret_nxt = psm_pkg::S_CLASS;
          state_nxt = psm_pkg::S_REL_A;
        end else begin
          ret_nxt = psm_pkg::S_FIN;
          state_nxt = psm_pkg::S_CLASS;
        end
      end
      psm_pkg::S_CLASS: begin
        ret_nxt = psm_pkg::S_FIN;
        if (!av_r) begin
          state_nxt = short_c ? psm_pkg::S_EMIT_INC : psm_pkg::S_SETA;
        end else if (short_c) begin
          hls_nxt = sum_c[16:0];
          if (sum_c < {2'b00, plateau_r} && count_r < CW'(HOLD_DEPTH)) begin
            we = 1'b1;
            count_nxt = count_r + CW'(1);
            state_nxt = psm_pkg::S_FIN;
          end else begin
            ret_nxt = psm_pkg::S_EMIT_INC;
            state_nxt = psm_pkg::S_REL_A;
          end
        end else if (gap_bad || val_bad) begin
          ret_nxt = psm_pkg::S_SETA;
          state_nxt = psm_pkg::S_REL_A;
        end else begin
          state_nxt = psm_pkg::S_MA;
        end
      end
      psm_pkg::S_SETA: begin
        av_nxt = 1'b1;
        as_nxt = it_s_r;
        ae_nxt = it_e_r;
        aval_nxt = it_v_r;
        an_nxt = {6'd0, it_n_r};
        count_nxt = '0;
        hls_nxt = '0;
        state_nxt = psm_pkg::S_FIN;
      end
      psm_pkg::S_EMIT_INC: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          og_nxt = it_grp_r;
          os_nxt = it_s_r;
          oe_nxt = it_e_r;
          ovl_nxt = it_v_r;
          on_nxt = {6'd0, it_n_r};
          state_nxt = psm_pkg::S_FIN;
        end
      end
      psm_pkg::S_REL_A: begin
        idx_nxt = '0;
        if (!av_r) begin
          if (count_r != '0) begin
            state_nxt = psm_pkg::S_REL_RD;
          end else begin
            hls_nxt = '0;
            state_nxt = ret_r;
          end
        end else if (out_free) begin
          ov_nxt = 1'b1;
          ol_nxt = (count_r == '0) && !inc_follows;
          og_nxt = prev_r;
          os_nxt = as_r;
          oe_nxt = ae_r;
          ovl_nxt = aval_r;
          on_nxt = an_r;
          av_nxt = 1'b0;
          if (count_r != '0) begin
            state_nxt = psm_pkg::S_REL_RD;
          end else begin
            hls_nxt = '0;
            state_nxt = ret_r;
          end
        end
      end
      psm_pkg::S_REL_RD: begin
        state_nxt = psm_pkg::S_REL_HE;
      end
      psm_pkg::S_REL_HE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ol_nxt = (idx_r + CW'(1) == count_r) && !inc_follows;
          og_nxt = prev_r;
          os_nxt = hs_c;
          oe_nxt = he_c;
          ovl_nxt = hv_c;
          on_nxt = {6'd0, hn_c};
          if (idx_r + CW'(1) == count_r) begin
            av_nxt = 1'b0;
            count_nxt = '0;
            hls_nxt = '0;
            state_nxt = ret_r;
          end else begin
            idx_nxt = idx_r + CW'(1);
            state_nxt = psm_pkg::S_REL_RD;
          end
        end
      end
      psm_pkg::S_MA: begin
        prod_nxt = prod_c;
        d_nxt = DW'(wa_c);
        nsum_nxt = {2'b00, an_r} + {8'd0, it_n_r};
        state_nxt = psm_pkg::S_AA;
      end
      psm_pkg::S_AA: begin
        acc_nxt = {{(AW-66){prod_r[65]}}, prod_r};
        state_nxt = psm_pkg::S_MI;
      end
      psm_pkg::S_MI: begin
        prod_nxt = prod_c;
        d_nxt = d_r + DW'(wi_c);
        state_nxt = psm_pkg::S_AI;
      end
      psm_pkg::S_AI: begin
        acc_nxt = acc_r + {{(AW-66){prod_r[65]}}, prod_r};
        dsel_nxt = 1'b0;
        state_nxt = psm_pkg::S_DSET;
      end
      psm_pkg::S_DSET: begin
        neg_nxt = acc_r[AW-1];
        rem_nxt = mag_c[32+DW-1:32];
        lo_nxt = mag_c[31:0];
        q_nxt = '0;
        dcnt_nxt = '0;
        if (d_r == '0) begin
          if (dsel_r) begin
            tv2_nxt = '0;
            state_nxt = psm_pkg::S_CMP;
          end else begin
            tv1_nxt = '0;
            idx_nxt = '0;
            state_nxt = psm_pkg::S_HCHK;
          end
        end else begin
          state_nxt = psm_pkg::S_DRUN;
        end
      end
      psm_pkg::S_DRUN: begin
        rem_nxt = ge_c ? DW'(t_c - {1'b0, d_r}) : t_c[DW-1:0];
        lo_nxt = {lo_r[30:0], 1'b0};
        q_nxt = {q_r[30:0], ge_c};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          state_nxt = psm_pkg::S_FIN;
        end
        if (dcnt_r == 5'd31 && dsel_r) begin
          state_nxt = psm_pkg::S_CMP;
        end else if (dcnt_r == 5'd31) begin
          idx_nxt = '0;
          state_nxt = psm_pkg::S_HCHK;
        end
      end
      psm_pkg::S_HCHK: begin
        if (dsel_r == 1'b0 && dcnt_r == '0 && d_r != '0) begin
          tv1_nxt = tv1_r;
        end
        if (idx_r == count_r) begin
          dsel_nxt = 1'b1;
          state_nxt = psm_pkg::S_DSET;
        end else begin
          state_nxt = psm_pkg::S_HRD;
        end
      end
      psm_pkg::S_HRD: begin
        state_nxt = psm_pkg::S_HMUL;
      end
      psm_pkg::S_HMUL: begin
        prod_nxt = prod_c;
        d_nxt = d_r + DW'(hw_c);
        nsum_nxt = nsum_r + {8'd0, hn_c};
        state_nxt = psm_pkg::S_HACC;
      end
      psm_pkg::S_HACC: begin
        acc_nxt = acc_r + {{(AW-66){prod_r[65]}}, prod_r};
        idx_nxt = idx_r + CW'(1);
        state_nxt = psm_pkg::S_HCHK;
      end
      psm_pkg::S_CMP: begin
        if (psm_pkg::abs_diff(tv1_r, tv2_r) > {2'b00, tol_r}) begin
          ret_nxt = psm_pkg::S_SETA;
          state_nxt = psm_pkg::S_REL_A;
        end else begin
          ae_nxt = it_e_r;
          aval_nxt = tv2_r;
          an_nxt = (nsum_r > {2'b00, psm_pkg::NODE_MAX}) ? psm_pkg::NODE_MAX : nsum_r[21:0];
          count_nxt = '0;
          hls_nxt = '0;
          state_nxt = psm_pkg::S_FIN;
        end
      end
      psm_pkg::S_FIN: begin
        if (it_op_r) begin
          seen_nxt = 1'b0;
        end else begin
          seen_nxt = 1'b1;
          prev_nxt = it_grp_r;
        end
        state_nxt = psm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = psm_pkg::S_IDLE;
      end
    endcase

    if (state_r == psm_pkg::S_DRUN && dcnt_r == 5'd31) begin
      if (dsel_r) begin
        tv2_nxt = neg_r ? (~{q_r[30:0], ge_c} + 32'd1) : {q_r[30:0], ge_c};
      end else begin
        tv1_nxt = neg_r ? (~{q_r[30:0], ge_c} + 32'd1) : {q_r[30:0], ge_c};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psm_pkg::S_IDLE;
      ret_r <= psm_pkg::S_FIN;
      max_gap_r <= 24'd500;
      tol_r <= '0;
      plateau_r <= 16'd50;
      wmode_r <= 1'b1;
      seen_r <= 1'b0;
      prev_r <= '0;
      av_r <= 1'b0;
      as_r <= '0;
      ae_r <= '0;
      aval_r <= '0;
      an_r <= '0;
      count_r <= '0;
      idx_r <= '0;
      hls_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      seen_r <= seen_nxt;
      prev_r <= prev_nxt;
      av_r <= av_nxt;
      as_r <= as_nxt;
      ae_r <= ae_nxt;
      aval_r <= aval_nxt;
      an_r <= an_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
      hls_r <= hls_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          psm_pkg::CFG_MAX_GAP:     max_gap_r <= cfg_data[23:0];
          psm_pkg::CFG_TOLERANCE:   tol_r <= cfg_data;
          psm_pkg::CFG_PLATEAU:     plateau_r <= cfg_data[15:0];
          psm_pkg::CFG_WEIGHT_MODE: wmode_r <= cfg_data[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == psm_pkg::S_IDLE && in_valid) begin
      it_op_r <= in_opcode;
      it_grp_r <= in_group_tag;
      it_s_r <= in_seg_start;
      it_e_r <= in_seg_end;
      it_v_r <= in_seg_value;
      it_n_r <= in_node_count;
    end
    prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    d_r <= d_nxt;
    nsum_r <= nsum_nxt;
    rem_r <= rem_nxt;
    lo_r <= lo_nxt;
    q_r <= q_nxt;
    neg_r <= neg_nxt;
    dsel_r <= dsel_nxt;
    dcnt_r <= dcnt_nxt;
    tv1_r <= tv1_nxt;
    tv2_r <= tv2_nxt;
    ol_r <= ol_nxt;
    og_r <= og_nxt;
    os_r <= os_nxt;
    oe_r <= oe_nxt;
    ovl_r <= ovl_nxt;
    on_r <= on_nxt;
  end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the plateau segment merger with a cycle-free predictor.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [15:0] grp;
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] v;
    logic [21:0] nodes;
    logic        last;
  } seg_beat_t;

  localparam int HOLD = 32;
  localparam int SETTLE = 400;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = psm_pkg::CFG_MAX_GAP;
  logic [30:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic in_opcode = 0;
  logic [15:0] in_group_tag = '0;
  logic [31:0] in_seg_start = '0;
  logic [31:0] in_seg_end = '0;
  logic signed [31:0] in_seg_value = '0;
  logic [15:0] in_node_count = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_group;
  logic [31:0] out_start, out_end;
  logic signed [31:0] out_value;
  logic [21:0] out_nodes;
  logic out_last;

  plateau_segment_merger DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Mirror of configuration and merger state.
  logic [23:0] m_gap;
  logic [30:0] m_tol;
  logic [15:0] m_plateau;
  logic m_wmode;
  logic m_seen, m_anchor;
  logic [15:0] m_group;
  logic [31:0] a_s, a_e, a_v;
  logic [21:0] a_n;
  logic [31:0] h_s[HOLD], h_e[HOLD], h_v[HOLD];
  logic [15:0] h_n[HOLD];
  int h_cnt;
  logic [16:0] h_sum;

  seg_beat_t released_q[$];
  int errors = 0;
  int item_cnt = 0;
  bit idle_on = 1;

  function automatic logic [63:0] seglen(logic [31:0] s, logic [31:0] e);
    return (e >= s) ? ({32'd0, e} - {32'd0, s} + 64'd1) : 64'd0;
  endfunction

  function automatic logic signed [127:0] wterm(logic [31:0] v, logic [63:0] w);
    return $signed({{96{v[31]}}, v}) * $signed({64'd0, w});
  endfunction

  function automatic logic signed [127:0] wmean(logic signed [127:0] acc,
                                                logic signed [127:0] d);
    return (d == 0) ? 128'sd0 : acc / d;
  endfunction

  function automatic logic [21:0] sat22(logic [63:0] x);
    return (x > 64'(psm_pkg::NODE_MAX)) ? psm_pkg::NODE_MAX : x[21:0];
  endfunction

  task automatic emit_beat(logic [31:0] s, logic [31:0] e, logic [31:0] v, logic [63:0] n);
    seg_beat_t b;
    b.grp = m_group; b.s = s; b.e = e; b.v = v; b.nodes = sat22(n); b.last = 0;
    released_q = {released_q, b};
  endtask

  task automatic release_all();
    if (m_anchor) emit_beat(a_s, a_e, a_v, 64'(a_n));
    for (int i = 0; i < h_cnt; i++) emit_beat(h_s[i], h_e[i], h_v[i], 64'(h_n[i]));
    m_anchor = 0; h_cnt = 0; h_sum = 0;
  endtask

  task automatic take_anchor(logic [31:0] s, logic [31:0] e, logic [31:0] v, logic [15:0] n);
    m_anchor = 1; a_s = s; a_e = e; a_v = v; a_n = 22'(n); h_cnt = 0; h_sum = 0;
  endtask

  function automatic bit merge_anchor(logic [31:0] s, logic [31:0] e, logic [31:0] v,
                                      logic [15:0] n, logic [63:0] len);
    logic signed [63:0] gap, diff;
    logic signed [127:0] acc, d, tv1, tv2, dd;
    logic [63:0] wa, wi, hw, nsum;
    gap = $signed({32'd0, s}) - $signed({32'd0, a_e});
    if (gap > $signed({40'd0, m_gap})) return 0;
    diff = $signed({{32{v[31]}}, v}) - $signed({{32{a_v[31]}}, a_v});
    if (diff < 0) diff = -diff;
    if (diff > $signed({33'd0, m_tol})) return 0;
    wa = m_wmode ? seglen(a_s, a_e) : 64'(a_n);
    wi = m_wmode ? len : 64'(n);
    acc = wterm(a_v, wa) + wterm(v, wi);
    d = $signed({64'd0, wa}) + $signed({64'd0, wi});
    tv1 = wmean(acc, d);
    nsum = 0;
    for (int i = 0; i < h_cnt; i++) begin
      hw = m_wmode ? seglen(h_s[i], h_e[i]) : 64'(h_n[i]);
      acc = acc + wterm(h_v[i], hw);
      d = d + $signed({64'd0, hw});
      nsum = nsum + 64'(h_n[i]);
    end
    tv2 = wmean(acc, d);
    dd = tv1 - tv2;
    if (dd < 0) dd = -dd;
    if (dd > $signed({97'd0, m_tol})) return 0;
    nsum = nsum + 64'(a_n) + 64'(n);
    a_e = e; a_v = tv2[31:0]; a_n = sat22(nsum); h_cnt = 0; h_sum = 0;
    return 1;
  endfunction

  task automatic predict_item(logic op, logic [15:0] g, logic [31:0] s, logic [31:0] e,
                              logic [31:0] v, logic [15:0] n);
    int n0;
    logic [63:0] len;
    logic [31:0] sum;
    n0 = released_q.size();
    if (op) begin
      release_all();
      m_seen = 0;
    end else begin
      if (m_seen && g != m_group) release_all();
      m_seen = 1;
      m_group = g;
      len = seglen(s, e);
      if (!m_anchor) begin
        if (len < 64'(m_plateau)) emit_beat(s, e, v, 64'(n));
        else take_anchor(s, e, v, n);
      end else if (len < 64'(m_plateau)) begin
        sum = {15'd0, h_sum} + len[31:0];
        h_sum = sum[16:0];
        if (sum < 32'(m_plateau) && h_cnt < HOLD) begin
          h_s[h_cnt] = s; h_e[h_cnt] = e; h_v[h_cnt] = v; h_n[h_cnt] = n;
          h_cnt++;
        end else begin
          release_all();
          emit_beat(s, e, v, 64'(n));
        end
      end else if (!merge_anchor(s, e, v, n, len)) begin
        release_all();
        take_anchor(s, e, v, n);
      end
    end
    if (released_q.size() > n0) released_q[$].last = 1;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    seg_beat_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (released_q.size() == 0) begin
        report("unexpected beat start", 64'(out_start), 64'd0);
      end else begin
        w = released_q.pop_front();
        if (out_group !== w.grp) report("group", 64'(out_group), 64'(w.grp));
        if (out_start !== w.s) report("start", 64'(out_start), 64'(w.s));
        if (out_end !== w.e) report("end", 64'(out_end), 64'(w.e));
        if (out_value !== w.v) report("value", 64'(out_value), 64'(w.v));
        if (out_nodes !== w.nodes) report("nodes", 64'(out_nodes), 64'(w.nodes));
        if (out_last !== w.last) report("last", 64'(out_last), 64'(w.last));
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send_item(logic op, logic [15:0] g, logic [31:0] s, logic [31:0] e,
                           logic [31:0] v, logic [15:0] n);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op; in_group_tag <= g; in_seg_start <= s; in_seg_end <= e;
    in_seg_value <= v; in_node_count <= n;
    do @(posedge clk); while (in_stall);
    item_cnt++;
    predict_item(op, g, s, e, v, n);
  endtask

  task automatic send_seg(logic [15:0] g, logic [31:0] s, logic [31:0] e,
                          logic [31:0] v, logic [15:0] n);
    send_item(1'b0, g, s, e, v, n);
  endtask

  task automatic send_end();
    send_item(1'b1, 16'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (released_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      psm_pkg::CFG_MAX_GAP: m_gap = val[23:0];
      psm_pkg::CFG_TOLERANCE: m_tol = val;
      psm_pkg::CFG_PLATEAU: m_plateau = val[15:0];
      default: m_wmode = val[0];
    endcase
  endtask

  task automatic set_config(logic [23:0] gap, logic [30:0] tol, logic [15:0] pl, logic wm);
    drain();
    write_reg(psm_pkg::CFG_MAX_GAP, 31'(gap));
    write_reg(psm_pkg::CFG_TOLERANCE, tol);
    write_reg(psm_pkg::CFG_PLATEAU, 31'(pl));
    write_reg(psm_pkg::CFG_WEIGHT_MODE, 31'(wm));
  endtask

  task automatic test_directed();
    send_end();
    send_seg(16'h0000, 32'd0, 32'd99, 32'h0001_0000, 16'd10);
    send_seg(16'h0000, 32'd100, 32'd104, 32'h0001_0000, 16'd2);
    send_seg(16'h0000, 32'd110, 32'd200, 32'h0001_0000, 16'd7);
    send_seg(16'h0000, 32'd150, 32'd260, 32'h0001_0000, 16'd3);
    send_seg(16'h0000, 32'd90, 32'd80, 32'h8000_0000, 16'hFFFF);
    send_seg(16'h0000, 32'd300, 32'd400, 32'h7FFF_FFFF, 16'd0);
    send_seg(16'hFFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_seg(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 16'd1);
    send_end();
    send_end();
    set_config(24'hFFFFFF, 31'h7FFF_FFFF, 16'd10, 1'b0);
    send_seg(16'd3, 32'd0, 32'd20, 32'hFFF0_0000, 16'd0);
    send_seg(16'd3, 32'd21, 32'd22, 32'h0010_0000, 16'd0);
    send_seg(16'd3, 32'd30, 32'd50, 32'h0020_0000, 16'd0);
    send_seg(16'd4, 32'd60, 32'd90, 32'h8000_0000, 16'd9);
    send_seg(16'd4, 32'd91, 32'd120, 32'h7FFF_FFFF, 16'd9);
    send_end();
  endtask

  task automatic test_full_hold();
    set_config(24'd500, 31'd0, 16'hFFFF, 1'b1);
    send_seg(16'd7, 32'd0, 32'd65534, 32'h0002_0000, 16'd1);
    for (int i = 0; i < HOLD + 1; i++)
      send_seg(16'd7, 32'd65535 + 32'(i), 32'd65535 + 32'(i), $urandom, 16'($urandom));
    send_end();
  endtask

  task automatic test_node_saturation();
    set_config(24'hFFFFFF, 31'h7FFF_FFFF, 16'd1, 1'b0);
    for (int i = 0; i < 70; i++)
      send_seg(16'd9, 32'(i * 4), 32'(i * 4 + 3), 32'h0003_0000, 16'hFFFF);
    send_end();
  endtask

  task automatic test_hold_off();
    set_config(24'd1000, 31'd4096, 16'd40, 1'b1);
    send_seg(16'd2, 32'd0, 32'd60, 32'h0001_0000, 16'd5);
    send_seg(16'd2, 32'd61, 32'd70, 32'h0001_0800, 16'd5);
    send_seg(16'd2, 32'd75, 32'd140, 32'h0001_0400, 16'd5);
    in_valid <= 0;
    while (released_q.size() != 0) @(posedge clk);
    send_end();
  endtask

  task automatic send_chain(logic [15:0] g);
    logic [31:0] p, len, vb, off;
    int shorts, budget;
    p = $urandom_range(0, 32'h3FFF_FFFF);
    vb = $urandom;
    off = (m_tol > 31'd2000) ? 32'd2000 : 32'(m_tol);
    len = 32'(m_plateau) + $urandom_range(0, 30);
    send_seg(g, p, p + len - 1, vb, 16'($urandom));
    p = p + len;
    repeat ($urandom_range(1, 4)) begin
      shorts = $urandom_range(0, 5);
      budget = (m_plateau > 16'd1) ? (int'(m_plateau) - 1) / (shorts + 1) : 0;
      repeat (shorts) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, m_plateau);
        else len = $urandom_range(0, budget);
        if (len == 0) send_seg(g, p + 1, p, vb + $urandom_range(0, off), 16'($urandom));
        else send_seg(g, p, p + len - 1, vb + $urandom_range(0, off), 16'($urandom));
        p = p + len;
      end
      p = p + $urandom_range(0, (m_gap > 24'd50) ? 60 : int'(m_gap) + 3);
      len = 32'(m_plateau) + $urandom_range(0, 30);
      send_seg(g, p, p + len - 1, vb + $urandom_range(0, off) - off / 2, 16'($urandom));
      p = p + len;
    end
  endtask

  task automatic send_noise();
    send_item($urandom_range(0, 7) == 0, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd1,
              $urandom, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic test_random_phase(logic [23:0] gap, logic [30:0] tol, logic [15:0] pl,
                                   logic wm, int items);
    int start;
    logic [15:0] g;
    set_config(gap, tol, pl, wm);
    g = 16'($urandom);
    start = item_cnt;
    while (item_cnt - start < items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        if ($urandom_range(0, 3) == 0) g = 16'($urandom);
        send_chain(g);
        if ($urandom_range(0, 2) == 0) send_end();
      end
    end
    send_end();
  endtask

  initial begin
    m_gap = 24'd500; m_tol = 31'd0; m_plateau = 16'd50; m_wmode = 1;
    m_seen = 0; m_anchor = 0; m_group = 0; a_s = 0; a_e = 0; a_v = 0; a_n = 0;
    h_cnt = 0; h_sum = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_full_hold();
    test_node_saturation();
    test_hold_off();
    test_random_phase(24'd500, 31'd1000, 16'd50, 1'b1, 35);
    test_random_phase(24'd0, 31'd0, 16'd1, 1'b0, 25);
    test_random_phase(24'hFFFFFF, 31'h7FFF_FFFF, 16'd20, 1'b1, 35);
    test_random_phase(24'd30, 31'd2000, 16'd12, 1'b0, 35);
    test_random_phase(24'd100, 31'd500, 16'hFFFF, 1'b1, 20);
    idle_on = 0;
    test_random_phase(24'd200, 31'd1500, 16'd8, 1'b1, 35);
    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
